// File: hdl/bff_pkg.sv
// shared constants for the four-probe bloom filter
package bff_pkg;
   localparam logic [63:0] FMIX_C1     = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_C2     = 64'hc4ceb9fe1a85ec53;
   localparam logic [31:0] SEED_STEP   = 32'h9E3779B9;
   localparam logic [31:0] SEED_BASE   = 32'h00000001;
   localparam int          FMIX_SHIFT  = 33;
   localparam int          KEY_WORDS   = 4;
   localparam int          MIN_SIZE_LOG2 = 12;
   localparam logic        ACT_QUERY   = 1'b0;
   localparam logic        ACT_INSERT  = 1'b1;
endpackage

// File: hdl/bloom_filter_four_probe.sv
// top level of the four-probe bloom filter over 256-bit keys
// one request at a time: a request is taken at a clock edge with start high and
// busy low, busy rises the next cycle and stays high until the request is done,
// and start while busy is ignored. each probe hashes the four key words with
// fmix64 steps on one shared 32x32 multiplier: per word a key add step and two
// fmix64 calls (three shift steps, one mix step and two multiplies, each of
// three partial products taking a product and a sum step); then a bit-store
// read, a check and a done step, plus a write-back step for an insert. the
// time a request keeps busy high is set by the serial multiplier. a query
// gives one rsp_valid pulse carrying rsp_might_contain in the first cycle with
// busy low, so the next request can be taken at the end of that same cycle; an
// insert gives none. after reset the bit store is cleared one 64-bit word a
// cycle, all 2^(MAX_SIZE_LOG2-6) words (1024 by default), with busy high.
// the receiver cannot stall
module bloom_filter_four_probe #(
   parameter int MAX_SIZE_LOG2 = 16,
   parameter int PROBES        = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [63:0] req_key_word0,
   input  logic [63:0] req_key_word1,
   input  logic [63:0] req_key_word2,
   input  logic [63:0] req_key_word3,
   output logic        rsp_valid,
   output logic        rsp_might_contain,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);
   localparam int WA = MAX_SIZE_LOG2 - 6;
   localparam int DEPTH = 1 << WA;
   localparam int PW = (PROBES > 1) ? $clog2(PROBES) : 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ADD, S_SH1, S_MUL, S_MSUM, S_SH2, S_MIX, S_RD, S_CHK, S_WR, S_DONE
   } state_type;

   // bit store
   logic [63:0] mem [DEPTH];
   logic [63:0] rd_ff;
   logic        we;
   logic [WA-1:0] waddr, raddr;
   logic [63:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   state_type state_ff;
   logic [4:0]  size_ff;
   logic        act_ff;
   logic [63:0] w_ff [4];
   logic [PW-1:0] probe_ff;
   logic [1:0]  word_ff;
   logic        pass_ff;      // 0: mix of key word, 1: mix of hash
   logic        mul_ff;       // which constant
   logic [1:0]  pp_ff;        // partial product index
   logic [63:0] v_ff, h_ff, acc_ff, pp_res_ff;
   logic        all_ff;
   logic [WA-1:0] clr_ff;
   logic        rv_ff, rm_ff;
   logic [MAX_SIZE_LOG2-1:0] idx_ff;

   logic [31:0] seed;
   assign seed = 32'(probe_ff) * bff_pkg::SEED_STEP + bff_pkg::SEED_BASE;

   // effective size
   logic [4:0] sz;
   always_comb begin
      sz = size_ff;
      if (sz < 5'(bff_pkg::MIN_SIZE_LOG2)) sz = 5'(bff_pkg::MIN_SIZE_LOG2);
      if (32'(sz) > 32'(MAX_SIZE_LOG2)) sz = 5'(MAX_SIZE_LOG2);
   end

   // shared 32x32 multiplier, partial products of v * c modulo 2^64
   logic [63:0] cst;
   logic [31:0] ma, mb;
   logic [63:0] prod;
   assign cst = mul_ff ? bff_pkg::FMIX_C2 : bff_pkg::FMIX_C1;
   always_comb begin
      case (pp_ff)
         2'd0: begin ma = v_ff[31:0];  mb = cst[31:0];  end
         2'd1: begin ma = v_ff[63:32]; mb = cst[31:0];  end
         2'd2: begin ma = v_ff[31:0];  mb = cst[63:32]; end
         default: begin ma = v_ff[31:0]; mb = 32'd0; end
      endcase
      prod = 64'(ma) * 64'(mb);
   end

   logic [63:0] hmix;
   assign hmix = h_ff ^ (v_ff ^ (v_ff >> bff_pkg::FMIX_SHIFT));
   logic [MAX_SIZE_LOG2-1:0] idx_mask;
   assign idx_mask = MAX_SIZE_LOG2'((64'd1 << sz) - 64'd1);

   always_comb begin
      we = 1'b0; waddr = clr_ff; wdata = '0;
      raddr = idx_ff[MAX_SIZE_LOG2-1:6];
      if (state_ff == S_CLEAR) we = 1'b1;
      else if (state_ff == S_WR) begin
         we = 1'b1; waddr = idx_ff[MAX_SIZE_LOG2-1:6];
         wdata = rd_ff | (64'd1 << idx_ff[5:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; size_ff <= 5'd16; rv_ff <= 1'b0;
         rm_ff <= 1'b0;
      end else begin
         rv_ff <= 1'b0;
         if (csr_we) size_ff <= csr_wdata;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == WA'(DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               act_ff <= req_action;
               w_ff[0] <= req_key_word0; w_ff[1] <= req_key_word1;
               w_ff[2] <= req_key_word2; w_ff[3] <= req_key_word3;
               probe_ff <= '0; word_ff <= '0; pass_ff <= 1'b0; all_ff <= 1'b1;
               h_ff <= 64'(bff_pkg::SEED_BASE);
               state_ff <= S_ADD;
            end
            S_ADD: begin
               v_ff <= w_ff[word_ff] + 64'(seed) + 64'({word_ff, 3'b000});
               state_ff <= S_SH1;
            end
            S_SH1: begin
               v_ff <= v_ff ^ (v_ff >> bff_pkg::FMIX_SHIFT);
               mul_ff <= 1'b0; pp_ff <= '0; acc_ff <= '0; state_ff <= S_MUL;
            end
            S_MUL: begin
               pp_res_ff <= prod; state_ff <= S_MSUM;
            end
            S_MSUM: begin
               if (pp_ff == 2'd0) acc_ff <= acc_ff + pp_res_ff;
               else acc_ff <= acc_ff + {pp_res_ff[31:0], 32'd0};
               if (pp_ff == 2'd2) state_ff <= S_SH2;
               else begin pp_ff <= pp_ff + 1'b1; state_ff <= S_MUL; end
            end
            S_SH2: begin
               if (!mul_ff) begin
                  v_ff <= acc_ff ^ (acc_ff >> bff_pkg::FMIX_SHIFT);
                  mul_ff <= 1'b1; pp_ff <= '0; acc_ff <= '0; state_ff <= S_MUL;
               end else begin
                  v_ff <= acc_ff; state_ff <= S_MIX;
               end
            end
            S_MIX: begin
               if (!pass_ff) begin
                  v_ff <= hmix; h_ff <= hmix; pass_ff <= 1'b1; state_ff <= S_SH1;
               end else begin
                  // v holds fmix64 up to last shift; finish it
                  h_ff <= v_ff ^ (v_ff >> bff_pkg::FMIX_SHIFT);
                  pass_ff <= 1'b0;
                  if (word_ff == 2'd3) begin
                     idx_ff <= (v_ff[MAX_SIZE_LOG2-1:0] ^
                        v_ff[MAX_SIZE_LOG2+32:33]) & idx_mask;
                     state_ff <= S_RD;
                  end else begin
                     word_ff <= word_ff + 1'b1;
                     state_ff <= S_ADD;
                  end
               end
            end
            S_RD: state_ff <= S_CHK;
            S_CHK: begin
               if (act_ff == bff_pkg::ACT_INSERT) state_ff <= S_WR;
               else begin
                  if (!rd_ff[idx_ff[5:0]]) all_ff <= 1'b0;
                  state_ff <= S_DONE;
               end
            end
            S_WR: state_ff <= S_DONE;
            S_DONE: begin
               if (32'(probe_ff) == PROBES - 1) begin
                  rv_ff <= (act_ff == bff_pkg::ACT_QUERY);
                  rm_ff <= all_ff;
                  state_ff <= S_IDLE;
               end else begin
                  probe_ff <= probe_ff + 1'b1; word_ff <= '0;
                  h_ff <= 64'(32'(32'(probe_ff) + 1) * bff_pkg::SEED_STEP
                     + bff_pkg::SEED_BASE);
                  state_ff <= S_ADD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_might_contain = rm_ff;
endmodule

// File: hdl/bff_checker.sv
// port-level checks for the bloom filter, bound to the top level
module bff_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");
   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> !rsp_valid) else $error("response during work");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response longer than a cycle");
endmodule

bind bloom_filter_four_probe bff_checker u_bff_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid)
);

// File: tb/sv/bloom_filter_four_probe_tb.sv
// self-checking testbench for the four-probe bloom filter
module bloom_filter_four_probe_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIZE_LOG2_MAX = 16;
   localparam int PROBE_COUNT   = 4;
   localparam int SETTLE_CYCLES = 400;   // idle margin once the block has gone quiet
   localparam int STALL_LIMIT   = 8000;  // covers the post-reset clear plus the longest gap
   localparam int RANDOM_PER_PHASE = 105;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_action = bff_pkg::ACT_QUERY;
   logic [63:0] req_key_word0 = '0;
   logic [63:0] req_key_word1 = '0;
   logic [63:0] req_key_word2 = '0;
   logic [63:0] req_key_word3 = '0;
   logic        rsp_valid;
   logic        rsp_might_contain;
   logic        csr_we = 1'b0;
   logic [4:0]  csr_wdata = '0;

   bloom_filter_four_probe u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_key_word0     (req_key_word0),
      .req_key_word1     (req_key_word1),
      .req_key_word2     (req_key_word2),
      .req_key_word3     (req_key_word3),
      .rsp_valid         (rsp_valid),
      .rsp_might_contain (rsp_might_contain),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // one row of the directed table; the typed answer is used only when known
   typedef struct packed {
      logic        action;
      logic [63:0] w0;
      logic [63:0] w1;
      logic [63:0] w2;
      logic [63:0] w3;
      logic        answer_known;
      logic        answer;
   } key_row_type;

   // shadow of the bit store and the size register
   bit         shadow_bits [0:(1 << SIZE_LOG2_MAX) - 1];
   logic [4:0] shadow_size_log2;

   // membership answers still owed by the block, oldest first
   logic       pending_answers [$];
   int         error_count = 0;
   int         quiet_cycles = 0;

   // keys inserted so far, for follow-up queries
   logic [255:0] inserted_keys [$];

   // 64-bit murmur finalizer
   function automatic logic [63:0] murmur_final(logic [63:0] v);
      v = v ^ (v >> bff_pkg::FMIX_SHIFT);
      v = v * bff_pkg::FMIX_C1;
      v = v ^ (v >> bff_pkg::FMIX_SHIFT);
      v = v * bff_pkg::FMIX_C2;
      v = v ^ (v >> bff_pkg::FMIX_SHIFT);
      return v;
   endfunction

   // bit position chosen by one probe under the current size
   function automatic int unsigned probe_position(logic [255:0] key, int unsigned p);
      logic [31:0] seed;
      logic [63:0] h;
      logic [63:0] word;
      int unsigned n;
      seed = p * bff_pkg::SEED_STEP + bff_pkg::SEED_BASE;
      h = {32'h0, seed};
      for (int i = 0; i < bff_pkg::KEY_WORDS; i++) begin
         word = key[64*i +: 64];
         h = h ^ murmur_final(word + {32'h0, seed} + 64'(8 * i));
         h = murmur_final(h);
      end
      // out-of-range sizes saturate at both ends
      n = 32'(shadow_size_log2);
      if (n < bff_pkg::MIN_SIZE_LOG2) n = bff_pkg::MIN_SIZE_LOG2;
      if (n > SIZE_LOG2_MAX) n = SIZE_LOG2_MAX;
      return int'(h & ((64'd1 << n) - 64'd1));
   endfunction

   // apply one accepted request to the shadow; returns 1 when an answer is owed
   function automatic bit filter_update(logic action, logic [255:0] key, output logic hit);
      int unsigned pos;
      hit = 1'b1;
      for (int unsigned p = 0; p < PROBE_COUNT; p++) begin
         pos = probe_position(key, p);
         if (action == bff_pkg::ACT_INSERT) shadow_bits[pos] = 1'b1;
         else if (!shadow_bits[pos]) hit = 1'b0;
      end
      return action == bff_pkg::ACT_QUERY;
   endfunction

   // response checker: block cannot be stalled, so every strobe is taken
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual might_contain=%0b",
                     $time, rsp_might_contain);
            error_count++;
         end else begin
            logic want;
            want = pending_answers.pop_front();
            if (rsp_might_contain !== want) begin
               $display("%0t: might_contain mismatch, expected %0b, actual %0b",
                        $time, want, rsp_might_contain);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // hand one request to the block and log the answer it owes
   task automatic send_request(logic action, logic [255:0] key, int gap_pct,
                               logic answer_known, logic answer);
      logic hit;
      int   gap;
      if ($urandom_range(99) < gap_pct) begin
         // mostly short gaps, now and then a longer one
         gap = ($urandom_range(9) == 0) ? $urandom_range(400, 1) : $urandom_range(12, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_action    <= action;
      req_key_word0 <= key[63:0];
      req_key_word1 <= key[127:64];
      req_key_word2 <= key[191:128];
      req_key_word3 <= key[255:192];
      do @(posedge clock); while (busy);
      if (action == bff_pkg::ACT_INSERT) inserted_keys.push_back(key);
      if (filter_update(action, key, hit)) begin
         if (answer_known && answer !== hit) begin
            $display("%0t: table answer disagrees with prediction, expected %0b, actual %0b",
                     $time, answer, hit);
            error_count++;
         end
         pending_answers.push_back(hit);
      end
   endtask

   // drop start and let the block drain, including any trailing insert
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(logic [4:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow_size_log2 = value;
   endtask

   // random word, biased toward extremes now and then
   function automatic logic [63:0] pick_word;
      case ($urandom_range(7))
         0:       return 64'h0;
         1:       return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic logic [255:0] pick_key;
      return {pick_word(), pick_word(), pick_word(), pick_word()};
   endfunction

   key_row_type  key_table [15];
   logic [4:0]   size_plan [6];
   int           gap_plan  [6];
   logic [255:0] key;
   int           roll;

   initial begin
      // directed rows: empty filter misses, inserted keys hit, others predicted
      key_table = '{
         '{bff_pkg::ACT_QUERY,  64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 1'b0},
         '{bff_pkg::ACT_QUERY,  '1, '1, '1, '1, 1'b1, 1'b0},
         '{bff_pkg::ACT_INSERT, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0},
         '{bff_pkg::ACT_QUERY,  64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 1'b1},
         '{bff_pkg::ACT_INSERT, '1, '1, '1, '1, 1'b0, 1'b0},
         '{bff_pkg::ACT_QUERY,  '1, '1, '1, '1, 1'b1, 1'b1},
         '{bff_pkg::ACT_QUERY,  64'h1, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0},
         '{bff_pkg::ACT_QUERY,  64'h0, 64'h0, 64'h0, 64'h8000000000000000, 1'b0, 1'b0},
         '{bff_pkg::ACT_INSERT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
                                64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 1'b0},
         '{bff_pkg::ACT_QUERY,  64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
                                64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1, 1'b1},
         '{bff_pkg::ACT_QUERY,  64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
                                64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 1'b0},
         '{bff_pkg::ACT_INSERT, 64'h8000000000000000, 64'h1, '1, 64'h0, 1'b0, 1'b0},
         '{bff_pkg::ACT_QUERY,  64'h8000000000000000, 64'h1, '1, 64'h0, 1'b1, 1'b1},
         '{bff_pkg::ACT_QUERY,  64'h0123456789abcdef, 64'hfedcba9876543210,
                                64'h0, '1, 1'b0, 1'b0},
         '{bff_pkg::ACT_QUERY,  '1, 64'h0, '1, 64'h0, 1'b0, 1'b0}
      };
      // sizes: smallest, saturated low, saturated high, middles, back to reset value
      size_plan = '{5'd12, 5'd0, 5'd31, 5'd14, 5'd13, 5'd16};
      // sender idles lightly, then heavily, then not at all
      gap_plan  = '{6, 6, 60, 60, 0, 0};

      foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
      shadow_size_log2 = 5'd16;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // wait out the bit-store clear before touching the register
      @(posedge clock);
      while (busy) @(posedge clock);
      write_size(5'd16);

      foreach (key_table[i])
         send_request(key_table[i].action,
                      {key_table[i].w3, key_table[i].w2, key_table[i].w1, key_table[i].w0},
                      6, key_table[i].answer_known, key_table[i].answer);

      for (int ph = 0; ph < 6; ph++) begin
         // size changes land only on an idle block; the bit store keeps its contents
         drain();
         write_size(size_plan[ph]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            roll = $urandom_range(99);
            if (roll < 40) begin
               send_request(bff_pkg::ACT_INSERT, pick_key(), gap_plan[ph], 1'b0, 1'b0);
            end else if (roll < 75 && inserted_keys.size() != 0) begin
               // follow-up query of a known member, sometimes with one bit flipped
               key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
               if ($urandom_range(3) == 0) key[$urandom_range(255)] ^= 1'b1;
               send_request(bff_pkg::ACT_QUERY, key, gap_plan[ph], 1'b0, 1'b0);
            end else begin
               send_request(bff_pkg::ACT_QUERY, pick_key(), gap_plan[ph], 1'b0, 1'b0);
            end
            // sender holds off until everything owed has come back
            if (n == RANDOM_PER_PHASE / 2) begin
               start <= 1'b0;
               @(posedge clock);
               while (pending_answers.size() != 0 || busy) @(posedge clock);
            end
         end
      end

      drain();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// File: files.f
hdl/bff_pkg.sv
hdl/bloom_filter_four_probe.sv
hdl/bff_checker.sv
tb/sv/bloom_filter_four_probe_tb.sv
